/* src/wsi_pkg.sv */
// ----------------------------------------------------------------------------
// wsi_pkg: shared types and constants of the windowed Simpson integrator
// Field widths, status codes, register indexes, sequencer states and the
// 48-bit saturation used by both the running sum and the final sum.
// ----------------------------------------------------------------------------
package wsi_pkg;

   localparam int unsigned X_W       = 32;
   localparam int unsigned Y_W       = 32;
   localparam int unsigned SUM_W     = 48;
   localparam int unsigned SPAN_W    = 33;
   localparam int unsigned FRAC_W    = 16;
   localparam int unsigned ALU_W     = SPAN_W + SUM_W;
   localparam int unsigned QUO_W     = ALU_W - FRAC_W;
   localparam int unsigned OUT_CNT_W = 13;
   localparam int unsigned STATUS_W  = 2;
   localparam int unsigned STEP_W    = 7;

   localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_SINGLE = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_SAT    = 2'd3;

   localparam logic CSR_IDX_START = 1'b0;
   localparam logic CSR_IDX_STOP  = 1'b1;

   localparam logic [SUM_W-1:0] SUM_MAX = 48'h7FFF_FFFF_FFFF;
   localparam logic [SUM_W-1:0] SUM_MIN = 48'h8000_0000_0000;

   typedef enum logic [3:0] {
      ENG_IDLE,
      ENG_SUM,
      ENG_SUM_ABS,
      ENG_SPAN,
      ENG_SPAN_ABS,
      ENG_MUL,
      ENG_DIV,
      ENG_FIX,
      ENG_DONE
   } eng_state_type;

   typedef struct packed {
      logic idle;
      logic done;
   } eng_stat_type;

   // Clamp a wide signed value to the 48-bit signed range.
   function automatic logic [SUM_W-1:0] sat_sum(input logic [ALU_W-1:0] r);
      logic hi_zero;
      logic hi_ones;
      hi_zero = ~|r[ALU_W-1:SUM_W-1];
      hi_ones = &r[ALU_W-1:SUM_W-1];
      if (hi_zero || hi_ones) begin
         return r[SUM_W-1:0];
      end else if (r[ALU_W-1]) begin
         return SUM_MIN;
      end else begin
         return SUM_MAX;
      end
   endfunction

endpackage

/* src/wsi_alu.sv */
// ----------------------------------------------------------------------------
// wsi_alu: shared adder of the integrator
// One 81-bit add with carry in. The sequencer uses it for the final sum,
// negations, the span, each multiply step and each divide step.
// ----------------------------------------------------------------------------
module wsi_alu
   import wsi_pkg::*;
(
   input  logic [ALU_W-1:0] op_a,
   input  logic [ALU_W-1:0] op_b,
   input  logic             carry_in,
   output logic [ALU_W-1:0] result
);

   assign result = op_a + op_b + {{(ALU_W-1){1'b0}}, carry_in};

endmodule

/* src/wsi_accum.sv */
// ----------------------------------------------------------------------------
// wsi_accum: window gate and weighted running sum
// Decides per sample whether it lies in the window and folds the previous
// accepted sample into the sum with its Simpson weight. Next values are also
// handed out so the last beat of a set can be captured by the sequencer.
// ----------------------------------------------------------------------------
module wsi_accum
   import wsi_pkg::*;
#(
   parameter int unsigned MAX_POINTS = 4096,
   parameter int unsigned CW         = 13
)(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    beat,
   input  logic signed [X_W-1:0]   x_sample,
   input  logic signed [Y_W-1:0]   y_sample,
   input  logic                    last_of_set,
   input  logic signed [X_W-1:0]   window_start,
   input  logic signed [X_W-1:0]   window_stop,
   output logic [CW-1:0]           count_next,
   output logic [SUM_W-1:0]        sum_next,
   output logic [Y_W-1:0]          pend_next
);

   logic                inside_ff, inside_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [SUM_W-1:0]    ws_ff, ws_in;
   logic [Y_W-1:0]      pend_ff, pend_in;
   logic                take;
   logic [SUM_W+1:0]    pend_wt;
   logic [SUM_W+1:0]    raw_sum;

   always_comb begin
      inside_in = inside_ff | (x_sample >= window_start);
      take = inside_in && (x_sample <= window_stop) && (count_ff < CW'(MAX_POINTS));

      // Weight 1 for the first point, then 4 and 2 alternating.
      if (count_ff == CW'(1)) begin
         pend_wt = {{(SUM_W+2-Y_W){pend_ff[Y_W-1]}}, pend_ff};
      end else if (!count_ff[0]) begin
         pend_wt = {{(SUM_W-Y_W){pend_ff[Y_W-1]}}, pend_ff, 2'b00};
      end else begin
         pend_wt = {{(SUM_W+1-Y_W){pend_ff[Y_W-1]}}, pend_ff, 1'b0};
      end
      raw_sum = {{2{ws_ff[SUM_W-1]}}, ws_ff} + pend_wt;

      count_in = count_ff;
      ws_in = ws_ff;
      pend_in = pend_ff;
      if (take) begin
         if (count_ff != CW'(0)) begin
            ws_in = sat_sum({{(ALU_W-SUM_W-2){raw_sum[SUM_W+1]}}, raw_sum});
         end
         pend_in = y_sample;
         count_in = count_ff + CW'(1);
      end
   end

   assign count_next = count_in;
   assign sum_next = ws_in;
   assign pend_next = pend_in;

   always_ff @(posedge clock) begin
      if (reset || (beat && last_of_set)) begin
         inside_ff <= 1'b0;
         count_ff <= '0;
         ws_ff <= '0;
         pend_ff <= '0;
      end else if (beat) begin
         inside_ff <= inside_in;
         count_ff <= count_in;
         ws_ff <= ws_in;
         pend_ff <= pend_in;
      end
   end

endmodule

/* src/wsi_engine.sv */
// ----------------------------------------------------------------------------
// wsi_engine: end-of-set sequencer
// Finishes the sum, takes magnitudes, multiplies span by sum one bit a step,
// divides by three times the interval count one quotient bit a step, then
// restores the sign and saturates. The sum, magnitude, span, product, quotient
// and sign arithmetic runs through wsi_alu.
module wsi_engine
   import wsi_pkg::*;
#(
   parameter int unsigned CW = 13
)(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [CW-1:0]         count_data,
   input  logic [SUM_W-1:0]      sum_data,
   input  logic [Y_W-1:0]        pend_data,
   input  logic [X_W-1:0]        window_start,
   input  logic [X_W-1:0]        window_stop,
   input  logic                  take,
   output eng_stat_type          stat,
   output logic [SUM_W-1:0]      integral,
   output logic [STATUS_W-1:0]   status,
   output logic [OUT_CNT_W-1:0]  points_used
);

   localparam int unsigned MW = CW + 2;
   localparam int unsigned RW = CW + 3;

   eng_state_type state_ff, state_in;

   logic [STEP_W-1:0]     step_ff, step_in;
   logic [SUM_W-1:0]      sum_ff, sum_in;
   logic [Y_W-1:0]        pend_ff, pend_in;
   logic [SPAN_W-1:0]     span_ff, span_in;
   logic                  neg_ff, neg_in;
   logic [ALU_W-1:0]      prod_ff, prod_in;
   logic [RW-1:0]         rem_ff, rem_in;
   logic [MW-1:0]         m_ff, m_in;
   logic [SUM_W-1:0]      integral_ff, integral_in;
   logic [STATUS_W-1:0]   status_ff, status_in;
   logic [OUT_CNT_W-1:0]  points_ff, points_in;

   logic [ALU_W-1:0]      op_a, op_b, alu_r;
   logic                  carry_in;
   logic [CW-1:0]         cm1;
   logic [RW-1:0]         rem_sh;
   logic [QUO_W-1:0]      quo;
   logic                  qbit;

   wsi_alu u_alu (
      .op_a     (op_a),
      .op_b     (op_b),
      .carry_in (carry_in),
      .result   (alu_r)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ENG_IDLE: begin
            if (start) begin
               if (count_data == CW'(0) || count_data == CW'(1)) begin
                  state_in = ENG_DONE;
               end else begin
                  state_in = ENG_SUM;
               end
            end
         end
         ENG_SUM:      state_in = ENG_SUM_ABS;
         ENG_SUM_ABS:  state_in = ENG_SPAN;
         ENG_SPAN:     state_in = ENG_SPAN_ABS;
         ENG_SPAN_ABS: state_in = ENG_MUL;
         ENG_MUL: begin
            if (step_ff == STEP_W'(SPAN_W-1)) begin
               state_in = ENG_DIV;
            end
         end
         ENG_DIV: begin
            if (step_ff == STEP_W'(QUO_W-1)) begin
               state_in = ENG_FIX;
            end
         end
         ENG_FIX: state_in = ENG_DONE;
         ENG_DONE: begin
            if (take) begin
               state_in = ENG_IDLE;
            end
         end
         default: state_in = ENG_IDLE;
      endcase
   end

   assign cm1 = count_data - CW'(1);
   assign rem_sh = {rem_ff[RW-2:0], prod_ff[ALU_W-1]};
   assign quo = prod_ff[ALU_W-1:FRAC_W];

   always_comb begin
      op_a = '0;
      op_b = '0;
      carry_in = 1'b0;
      qbit = 1'b0;
      step_in = step_ff;
      sum_in = sum_ff;
      pend_in = pend_ff;
      span_in = span_ff;
      neg_in = neg_ff;
      prod_in = prod_ff;
      rem_in = rem_ff;
      m_in = m_ff;
      integral_in = integral_ff;
      status_in = status_ff;
      points_in = points_ff;
      unique case (state_ff)
         ENG_IDLE: begin
            if (start) begin
               sum_in = sum_data;
               pend_in = pend_data;
               m_in = MW'({cm1, 1'b0}) + MW'(cm1);
               points_in = OUT_CNT_W'(count_data);
               integral_in = '0;
               if (count_data == CW'(0)) begin
                  status_in = STATUS_EMPTY;
               end else if (count_data == CW'(1)) begin
                  status_in = STATUS_SINGLE;
               end else begin
                  status_in = STATUS_OK;
               end
            end
         end
         ENG_SUM: begin
            op_a = {{(ALU_W-SUM_W){sum_ff[SUM_W-1]}}, sum_ff};
            op_b = {{(ALU_W-Y_W){pend_ff[Y_W-1]}}, pend_ff};
            sum_in = sat_sum(alu_r);
         end
         ENG_SUM_ABS: begin
            op_b = ~{{(ALU_W-SUM_W){sum_ff[SUM_W-1]}}, sum_ff};
            carry_in = 1'b1;
            neg_in = sum_ff[SUM_W-1];
            if (sum_ff[SUM_W-1]) begin
               sum_in = alu_r[SUM_W-1:0];
            end
         end
         ENG_SPAN: begin
            op_a = {{(ALU_W-X_W){window_stop[X_W-1]}}, window_stop};
            op_b = ~{{(ALU_W-X_W){window_start[X_W-1]}}, window_start};
            carry_in = 1'b1;
            span_in = alu_r[SPAN_W-1:0];
            neg_in = neg_ff ^ alu_r[SPAN_W-1];
         end
         ENG_SPAN_ABS: begin
            op_b = ~{{(ALU_W-SPAN_W){span_ff[SPAN_W-1]}}, span_ff};
            carry_in = 1'b1;
            if (span_ff[SPAN_W-1]) begin
               span_in = alu_r[SPAN_W-1:0];
            end
            prod_in = '0;
            step_in = '0;
         end
         ENG_MUL: begin
            // Most significant span bit first: shift the product, add the sum.
            op_a = {prod_ff[ALU_W-2:0], 1'b0};
            op_b = span_ff[SPAN_W-1] ? {{(ALU_W-SUM_W){1'b0}}, sum_ff} : '0;
            prod_in = alu_r;
            span_in = {span_ff[SPAN_W-2:0], 1'b0};
            if (step_ff == STEP_W'(SPAN_W-1)) begin
               step_in = '0;
               rem_in = '0;
            end else begin
               step_in = step_ff + STEP_W'(1);
            end
         end
         ENG_DIV: begin
            // The fraction bits are dropped first; only the upper product
            // bits pass through the divider, and quotient bits shift in.
            op_a = {{(ALU_W-RW){1'b0}}, rem_sh};
            op_b = ~{{(ALU_W-MW){1'b0}}, m_ff};
            carry_in = 1'b1;
            qbit = ~alu_r[ALU_W-1];
            rem_in = qbit ? alu_r[RW-1:0] : rem_sh;
            prod_in = {prod_ff[ALU_W-2:FRAC_W], qbit, {FRAC_W{1'b0}}};
            step_in = step_ff + STEP_W'(1);
         end
         ENG_FIX: begin
            op_b = ~{{(ALU_W-QUO_W){1'b0}}, quo};
            carry_in = 1'b1;
            if (neg_ff) begin
               if ((|quo[QUO_W-1:SUM_W]) || (quo[SUM_W-1] && (|quo[SUM_W-2:0]))) begin
                  integral_in = SUM_MIN;
                  status_in = STATUS_SAT;
               end else begin
                  integral_in = alu_r[SUM_W-1:0];
               end
            end else begin
               if (|quo[QUO_W-1:SUM_W-1]) begin
                  integral_in = SUM_MAX;
                  status_in = STATUS_SAT;
               end else begin
                  integral_in = quo[SUM_W-1:0];
               end
            end
         end
         ENG_DONE: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ENG_IDLE;
         step_ff <= '0;
      end else begin
         state_ff <= state_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      sum_ff <= sum_in;
      pend_ff <= pend_in;
      span_ff <= span_in;
      neg_ff <= neg_in;
      prod_ff <= prod_in;
      rem_ff <= rem_in;
      m_ff <= m_in;
      integral_ff <= integral_in;
      status_ff <= status_in;
      points_ff <= points_in;
   end

   assign stat.idle = (state_ff == ENG_IDLE);
   assign stat.done = (state_ff == ENG_DONE);
   assign integral = integral_ff;
   assign status = status_ff;
   assign points_used = points_ff;

endmodule

/* src/windowed_simpson_integrator.sv */
// ----------------------------------------------------------------------------
// windowed_simpson_integrator: Simpson integral of a sample set over a window
// Top level with the register port, window gate, end-of-set sequencer and
// the result register.
// ----------------------------------------------------------------------------
// Samples that do not end a set are taken one per cycle. The last sample of
// a set starts the sequencer, and the input is not ready again until its
// result has moved into the output register. An empty window or a single
// point goes straight to the hand-off; otherwise come the load, final sum,
// sum magnitude, span, span magnitude, 33 multiply steps, 65 divide steps,
// the sign and saturation step and the hand-off, all paced by the one shared
// 81-bit adder. The output register lets the next set stream in while a
// result waits to be taken. window_start sits at address 0, window_stop at 4.
module windowed_simpson_integrator
   import wsi_pkg::*;
#(
   parameter int unsigned MAX_POINTS = 4096
)(
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic signed [X_W-1:0]        req_x_sample,
   input  logic signed [Y_W-1:0]        req_y_sample,
   input  logic                         req_last_of_set,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic signed [SUM_W-1:0]      rsp_integral,
   output logic [STATUS_W-1:0]          rsp_status,
   output logic [OUT_CNT_W-1:0]         rsp_points_used,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [2:0]                   paddr,
   input  logic [31:0]                  pwdata,
   output logic [31:0]                  prdata,
   output logic                         pready
);

   localparam int unsigned CW = $clog2(MAX_POINTS + 1);

   logic signed [X_W-1:0]  start_ff, start_in;
   logic signed [X_W-1:0]  stop_ff, stop_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [SUM_W-1:0]       integral_ff;
   logic [STATUS_W-1:0]    status_ff;
   logic [OUT_CNT_W-1:0]   points_ff;

   logic                   beat;
   logic                   csr_write;
   logic                   take;
   logic [CW-1:0]          count_next;
   logic [SUM_W-1:0]       sum_next;
   logic [Y_W-1:0]         pend_next;
   eng_stat_type           stat;
   logic [SUM_W-1:0]       eng_integral;
   logic [STATUS_W-1:0]    eng_status;
   logic [OUT_CNT_W-1:0]   eng_points;

   assign pready = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign prdata = (paddr[2] == CSR_IDX_STOP) ? stop_ff : start_ff;

   always_comb begin
      start_in = start_ff;
      stop_in = stop_ff;
      if (csr_write) begin
         unique case (paddr[2])
            CSR_IDX_START: start_in = pwdata;
            CSR_IDX_STOP:  stop_in = pwdata;
            default: begin
            end
         endcase
      end
   end

   assign req_ready = stat.idle && !reset;
   assign beat = req_valid && req_ready;
   assign take = stat.done && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (take) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   wsi_accum #(
      .MAX_POINTS (MAX_POINTS),
      .CW         (CW)
   ) u_accum (
      .clock        (clock),
      .reset        (reset),
      .beat         (beat),
      .x_sample     (req_x_sample),
      .y_sample     (req_y_sample),
      .last_of_set  (req_last_of_set),
      .window_start (start_ff),
      .window_stop  (stop_ff),
      .count_next   (count_next),
      .sum_next     (sum_next),
      .pend_next    (pend_next)
   );

   wsi_engine #(
      .CW (CW)
   ) u_engine (
      .clock        (clock),
      .reset        (reset),
      .start        (beat && req_last_of_set),
      .count_data   (count_next),
      .sum_data     (sum_next),
      .pend_data    (pend_next),
      .window_start (start_ff),
      .window_stop  (stop_ff),
      .take         (take),
      .stat         (stat),
      .integral     (eng_integral),
      .status       (eng_status),
      .points_used  (eng_points)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff <= '0;
         stop_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         start_ff <= start_in;
         stop_ff <= stop_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         integral_ff <= eng_integral;
         status_ff <= eng_status;
         points_ff <= eng_points;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_integral = integral_ff;
   assign rsp_status = status_ff;
   assign rsp_points_used = points_ff;

endmodule

/* tb/windowed_simpson_integrator_test.sv */
// ----------------------------------------------------------------------------
// windowed_simpson_integrator_test: self-checking bench of the Simpson integrator
// Writes the window through the register port, streams sample sets through
// the valid/ready input with random gaps, stalls the result side at random
// and compares each result beat with an in-bench Simpson predictor or typed row.
// ----------------------------------------------------------------------------
module windowed_simpson_integrator_test
   import wsi_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned MAX_POINTS_CAP  = 4096;
   localparam int unsigned DRAIN_CYCLES    = 128;
   localparam int unsigned NUM_PHASES      = 12;
   localparam int unsigned LONG_SET_PHASE  = 3;
   localparam int unsigned LONG_SET_LEN    = 48;
   localparam int unsigned ITEMS_PER_PHASE = 85;
   localparam int unsigned NUM_DIR_ROWS    = 28;
   localparam int unsigned SHOW_LIMIT      = 10;

   localparam logic [2:0] ADDR_START = {CSR_IDX_START, 2'b00};
   localparam logic [2:0] ADDR_STOP  = {CSR_IDX_STOP, 2'b00};

   localparam logic [31:0] X_MIN = 32'h8000_0000;
   localparam logic [31:0] X_MAX = 32'h7FFF_FFFF;
   localparam logic [31:0] Q_ONE = 32'h0001_0000;

   localparam longint X_HI   = 64'sd2147483647;
   localparam longint X_LO   = -64'sd2147483648;
   localparam longint SUM_HI = 64'sd140737488355327;
   localparam longint SUM_LO = -64'sd140737488355328;

   localparam logic [127:0] POS_LIMIT = 128'h7FFF_FFFF_FFFF;
   localparam logic [127:0] NEG_LIMIT = 128'h8000_0000_0000;

   typedef struct packed {
      logic signed [SUM_W-1:0] integral;
      logic [STATUS_W-1:0]     status;
      logic [OUT_CNT_W-1:0]    points_used;
   } simpson_result_type;

   typedef enum logic [1:0] {
      ROW_WINDOW,
      ROW_PREDICTED,
      ROW_TYPED
   } row_kind_type;

   // For a window row, x carries window_start and y carries window_stop.
   typedef struct {
      row_kind_type       kind;
      logic [31:0]        x;
      logic [31:0]        y;
      logic               last;
      simpson_result_type result;
   } stim_row_type;

   localparam simpson_result_type RES_NONE   = '0;
   localparam simpson_result_type RES_EMPTY  = '{integral: '0, status: STATUS_EMPTY,
                                                 points_used: '0};
   localparam simpson_result_type RES_SINGLE = '{integral: '0, status: STATUS_SINGLE,
                                                 points_used: 13'd1};

   logic                      clock;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic signed [X_W-1:0]     req_x_sample = '0;
   logic signed [Y_W-1:0]     req_y_sample = '0;
   logic                      req_last_of_set = 1'b0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic signed [SUM_W-1:0]   rsp_integral;
   logic [STATUS_W-1:0]       rsp_status;
   logic [OUT_CNT_W-1:0]      rsp_points_used;
   logic                      psel = 1'b0;
   logic                      penable = 1'b0;
   logic                      pwrite = 1'b0;
   logic [2:0]                paddr = '0;
   logic [31:0]               pwdata = '0;
   logic [31:0]               prdata;
   logic                      pready;

   // Predictor state: window registers and the running set.
   logic [31:0]     cfg_start;
   logic [31:0]     cfg_stop;
   bit              win_inside;
   int unsigned     win_count;
   longint          win_sum;
   int              win_pending;

   simpson_result_type awaited_results[$];
   int unsigned     err_count;
   int unsigned     shown_count;
   bit              req_quiet;
   bit              rsp_quiet;
   int unsigned     stall_left;

   stim_row_type dir_rows [NUM_DIR_ROWS] = '{
      '{ROW_TYPED,     32'h0000_0000, 32'd123,       1'b1, RES_SINGLE},
      '{ROW_TYPED,     32'hFFFF_FFFF, 32'd7,         1'b1, RES_EMPTY},
      '{ROW_TYPED,     32'h0000_0001, 32'd9,         1'b1, RES_EMPTY},
      '{ROW_WINDOW,    X_MIN,         X_MAX,         1'b0, RES_NONE},
      '{ROW_PREDICTED, X_MIN,         X_MAX,         1'b0, RES_NONE},
      '{ROW_PREDICTED, 32'h0000_0000, X_MAX,         1'b0, RES_NONE},
      '{ROW_PREDICTED, X_MAX,         X_MAX,         1'b1, RES_NONE},
      '{ROW_PREDICTED, X_MIN,         X_MIN,         1'b0, RES_NONE},
      '{ROW_PREDICTED, 32'h0000_0000, X_MIN,         1'b0, RES_NONE},
      '{ROW_PREDICTED, X_MAX,         X_MIN,         1'b1, RES_NONE},
      '{ROW_PREDICTED, 32'h0000_0000, Q_ONE,         1'b0, RES_NONE},
      '{ROW_PREDICTED, X_MAX,         Q_ONE,         1'b1, RES_NONE},
      '{ROW_WINDOW,    X_MAX,         X_MIN,         1'b0, RES_NONE},
      '{ROW_TYPED,     X_MAX,         32'd5,         1'b1, RES_EMPTY},
      '{ROW_PREDICTED, X_MAX,         32'd1,         1'b0, RES_NONE},
      '{ROW_PREDICTED, X_MIN,         32'd2,         1'b0, RES_NONE},
      '{ROW_PREDICTED, X_MIN,         32'd3,         1'b1, RES_NONE},
      '{ROW_WINDOW,    32'h0001_0000, 32'h0005_0000, 1'b0, RES_NONE},
      '{ROW_PREDICTED, 32'h0000_0000, X_MAX,         1'b0, RES_NONE},
      '{ROW_PREDICTED, 32'h0001_0000, 32'h0001_0000, 1'b0, RES_NONE},
      '{ROW_PREDICTED, 32'h0002_0000, 32'h0004_0000, 1'b0, RES_NONE},
      '{ROW_PREDICTED, 32'h0003_0000, 32'h0009_0000, 1'b0, RES_NONE},
      '{ROW_PREDICTED, 32'h0006_0000, X_MIN,         1'b1, RES_NONE},
      '{ROW_TYPED,     X_MAX,         32'd11,        1'b1, RES_EMPTY},
      '{ROW_PREDICTED, 32'h0001_0000, 32'hFFFF_0000, 1'b0, RES_NONE},
      '{ROW_PREDICTED, 32'h0002_0000, 32'h0003_0000, 1'b0, RES_NONE},
      '{ROW_PREDICTED, 32'h0003_0000, Q_ONE,         1'b0, RES_NONE},
      '{ROW_PREDICTED, 32'h0005_0000, 32'hFFFF_FFFF, 1'b1, RES_NONE}
   };

   windowed_simpson_integrator u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_x_sample    (req_x_sample),
      .req_y_sample    (req_y_sample),
      .req_last_of_set (req_last_of_set),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_integral    (rsp_integral),
      .rsp_status      (rsp_status),
      .rsp_points_used (rsp_points_used),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata),
      .pready          (pready)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #40ms;
      $display("Some tests failed");
      $finish;
   end

   function automatic longint sat48(input longint v);
      if (v > SUM_HI) begin
         return SUM_HI;
      end
      if (v < SUM_LO) begin
         return SUM_LO;
      end
      return v;
   endfunction

   function automatic logic [31:0] clamp_x(input longint v);
      if (v > X_HI) begin
         return X_MAX;
      end
      if (v < X_LO) begin
         return X_MIN;
      end
      return v[31:0];
   endfunction

   // Advances the running set by one sample; returns 1 when the sample ends
   // the set, with the integral, status and count that the set produces.
   function automatic bit simpson_predict(input logic [31:0] x, input logic [31:0] y,
                                          input logic last, output simpson_result_type res);
      longint       xs;
      longint       lo;
      longint       hi;
      longint       sum;
      longint       span;
      longint       weight;
      logic [63:0]  span_mag;
      logic [63:0]  sum_mag;
      logic [127:0] prod;
      logic [127:0] divisor;
      logic [127:0] quot;
      bit           neg;
      xs = longint'(signed'(x));
      lo = longint'(signed'(cfg_start));
      hi = longint'(signed'(cfg_stop));
      res = '0;
      if (xs >= lo) begin
         win_inside = 1'b1;
      end
      if (win_inside && xs <= hi && win_count < MAX_POINTS_CAP) begin
         // The held sample's weight is fixed only once a later one arrives.
         if (win_count > 0) begin
            if (win_count == 1) begin
               weight = 1;
            end else if ((win_count - 1) % 2 == 1) begin
               weight = 4;
            end else begin
               weight = 2;
            end
            win_sum = sat48(win_sum + weight * longint'(win_pending));
         end
         win_pending = signed'(y);
         win_count++;
      end
      if (!last) begin
         return 1'b0;
      end
      res.points_used = win_count[OUT_CNT_W-1:0];
      if (win_count == 0) begin
         res.status = STATUS_EMPTY;
      end else if (win_count == 1) begin
         res.status = STATUS_SINGLE;
      end else begin
         sum = sat48(win_sum + longint'(win_pending));
         span = hi - lo;
         neg = (span < 0) != (sum < 0);
         span_mag = (span < 0) ? -span : span;
         sum_mag = (sum < 0) ? -sum : sum;
         prod = {64'd0, span_mag} * {64'd0, sum_mag};
         divisor = 128'(3 * (win_count - 1)) << FRAC_W;
         quot = prod / divisor;
         res.status = STATUS_OK;
         if (neg) begin
            if (quot > NEG_LIMIT) begin
               res.integral = SUM_MIN;
               res.status = STATUS_SAT;
            end else begin
               res.integral = -quot[SUM_W-1:0];
            end
         end else if (quot > POS_LIMIT) begin
            res.integral = SUM_MAX;
            res.status = STATUS_SAT;
         end else begin
            res.integral = quot[SUM_W-1:0];
         end
      end
      win_inside = 1'b0;
      win_count = 0;
      win_sum = 0;
      win_pending = 0;
      return 1'b1;
   endfunction

   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (req_quiet || r < 55) begin
         return 0;
      end else if (r < 85) begin
         return $urandom_range(1, 3);
      end else if (r < 97) begin
         return $urandom_range(4, 12);
      end
      return $urandom_range(20, 60);
   endfunction

   function automatic int unsigned pick_stall();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 60) begin
         return 0;
      end else if (r < 90) begin
         return $urandom_range(1, 3);
      end else if (r < 98) begin
         return $urandom_range(4, 15);
      end
      return $urandom_range(30, 120);
   endfunction

   always @(posedge clock) begin
      if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
         if (!rsp_quiet) begin
            stall_left <= pick_stall();
         end
      end
   end

   // Result side: each beat is matched against the oldest awaited result.
   always @(posedge clock) begin
      simpson_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (awaited_results.size() == 0) begin
            err_count++;
            if (shown_count < SHOW_LIMIT) begin
               shown_count++;
               $display("unexpected result beat: integral %0d status %0d points %0d",
                        rsp_integral, rsp_status, rsp_points_used);
            end
         end else begin
            want = awaited_results.pop_front();
            if (rsp_integral !== want.integral || rsp_status !== want.status ||
                rsp_points_used !== want.points_used) begin
               err_count++;
               if (shown_count < SHOW_LIMIT) begin
                  shown_count++;
                  $display("result mismatch: expected integral %0d status %0d points %0d,",
                           want.integral, want.status, want.points_used);
                  $display("                 got integral %0d status %0d points %0d",
                           rsp_integral, rsp_status, rsp_points_used);
               end
            end
         end
      end
   end

   task automatic send_sample(input logic [31:0] x, input logic [31:0] y, input logic last,
                              input bit typed, input simpson_result_type typed_res);
      int unsigned        gap;
      simpson_result_type res;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_x_sample <= x;
      req_y_sample <= y;
      req_last_of_set <= last;
      do @(posedge clock); while (!req_ready);
      if (simpson_predict(x, y, last, res)) begin
         if (typed) begin
            res = typed_res;
         end
         awaited_results = {awaited_results, res};
      end
   endtask

   // Leaves the block idle: no beat in flight and no result outstanding.
   task automatic settle();
      req_valid <= 1'b0;
      while (awaited_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_access(input logic [2:0] addr, input bit wr, input logic [31:0] data);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= wr;
      paddr <= addr;
      pwdata <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (!wr && prdata !== data) begin
         err_count++;
         if (shown_count < SHOW_LIMIT) begin
            shown_count++;
            $display("register readback at %0d: expected %h, got %h", addr, data, prdata);
         end
      end
      psel <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_window(input logic [31:0] start_v, input logic [31:0] stop_v);
      csr_access(ADDR_START, 1'b1, start_v);
      csr_access(ADDR_STOP, 1'b1, stop_v);
      cfg_start = start_v;
      cfg_stop = stop_v;
      csr_access(ADDR_START, 1'b0, start_v);
      csr_access(ADDR_STOP, 1'b0, stop_v);
   endtask

   function automatic logic [31:0] pick_y();
      int unsigned r;
      r = $urandom_range(0, 19);
      if (r < 12) begin
         return $urandom;
      end else if (r < 17) begin
         return 32'($urandom_range(0, 1 << 21)) - (32'd1 << 20);
      end
      case ($urandom_range(0, 3))
         0: begin
            return X_MIN;
         end
         1: begin
            return X_MAX;
         end
         2: begin
            return 32'h0000_0000;
         end
         default: begin
            return 32'hFFFF_FFFF;
         end
      endcase
   endfunction

   // One set of samples. Most sets sweep rising x across the window; the
   // rest sit on the window edges or carry unordered x.
   task automatic send_set(input int unsigned len);
      longint      lo;
      longint      hi;
      longint      width;
      longint      stepmax;
      longint      cur;
      int unsigned xmode;
      int unsigned i;
      logic [31:0] xv;
      lo = longint'(signed'(cfg_start));
      hi = longint'(signed'(cfg_stop));
      width = hi - lo;
      if (width <= 0) begin
         width = 1 + $urandom_range(0, 1 << 20);
      end
      xmode = $urandom_range(0, 9);
      if (xmode == 9) begin
         stepmax = $urandom_range(1, 3);
         cur = lo - $urandom_range(0, 3);
      end else begin
         stepmax = (width * 3) / (2 * len) + 1;
         cur = lo - longint'({$urandom, $urandom} >> 1) % (width / 2 + 2);
      end
      for (i = 0; i < len; i++) begin
         if (xmode == 7) begin
            xv = $urandom;
         end else if (xmode == 8) begin
            xv = (i < len / 2) ? cfg_start : cfg_stop;
         end else begin
            xv = clamp_x(cur);
            cur = cur + 1 + longint'({$urandom, $urandom} >> 1) % stepmax;
         end
         send_sample(xv, pick_y(), i == len - 1, 1'b0, RES_NONE);
      end
   endtask

   function automatic int unsigned pick_set_len();
      int unsigned r;
      r = $urandom_range(0, 19);
      if (r < 14) begin
         return $urandom_range(1, 8);
      end else if (r < 18) begin
         return $urandom_range(9, 20);
      end
      return $urandom_range(21, 60);
   endfunction

   task automatic pick_window(input int unsigned phase);
      logic [31:0] start_v;
      longint      span;
      case (phase)
         0: begin
            set_window(X_MIN, X_MAX);
         end
         1: begin
            set_window(X_MAX, X_MIN);
         end
         2: begin
            set_window(32'h0000_0000, 32'h0000_0000);
         end
         LONG_SET_PHASE: begin
            set_window(32'h0000_0000, X_MAX);
         end
         default: begin
            start_v = $urandom;
            case ($urandom_range(0, 3))
               0: begin
                  span = $urandom_range(0, 1 << 20);
               end
               1: begin
                  span = $urandom_range(0, 1 << 28);
               end
               2: begin
                  span = $urandom;
               end
               default: begin
                  span = -longint'($urandom_range(0, 1 << 24));
               end
            endcase
            set_window(start_v, clamp_x(longint'(signed'(start_v)) + span));
         end
      endcase
   endtask

   initial begin
      int unsigned row;
      int unsigned phase;
      int unsigned sent;
      int unsigned len;
      int unsigned i;
      cfg_start = '0;
      cfg_stop = '0;
      win_inside = 1'b0;
      win_count = 0;
      win_sum = 0;
      win_pending = 0;
      err_count = 0;
      shown_count = 0;
      req_quiet = 1'b0;
      rsp_quiet = 1'b0;
      stall_left = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (row = 0; row < NUM_DIR_ROWS; row++) begin
         if (dir_rows[row].kind == ROW_WINDOW) begin
            settle();
            set_window(dir_rows[row].x, dir_rows[row].y);
         end else begin
            send_sample(dir_rows[row].x, dir_rows[row].y, dir_rows[row].last,
                        dir_rows[row].kind == ROW_TYPED, dir_rows[row].result);
         end
      end

      for (phase = 0; phase < NUM_PHASES; phase++) begin
         settle();
         pick_window(phase);
         req_quiet = ($urandom_range(0, 3) == 0);
         rsp_quiet = ($urandom_range(0, 3) == 0);
         if (phase == LONG_SET_PHASE) begin
            // One long set whose x starts just below the window.
            len = LONG_SET_LEN;
            for (i = 0; i < len; i++) begin
               send_sample(clamp_x(longint'(i) - 3), pick_y(), i == len - 1, 1'b0, RES_NONE);
            end
         end else begin
            sent = 0;
            while (sent < ITEMS_PER_PHASE) begin
               len = pick_set_len();
               send_set(len);
               sent += len;
            end
         end
      end

      settle();
      if (err_count == 0 && awaited_results.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
